// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Each check runs on the rising edge of clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/u8to16_pkg.sv =====
`default_nettype none

package u8to16_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;

    // Queue between decode and emit
    localparam int QDepth = 4;
    localparam int QAw    = 2;

    localparam logic [20:0] SuppBase = 21'h10000;
    localparam logic [15:0] HiSurr   = 16'hD800;
    localparam logic [15:0] LoSurr   = 16'hDC00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } byte_beat_t;

    typedef struct packed {
        logic [15:0] unit;
        logic        run_last;
        logic [1:0]  status;
    } unit_beat_t;

    // One decoded result: a single unit, or a code point to split into a pair
    typedef struct packed {
        logic        pair;
        logic [20:0] value;
        logic [1:0]  status;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_head_t;

endpackage

`default_nettype wire

// ===== rtl/utf8_to_utf16_transcoder.sv =====
`default_nettype none

// UTF-8 to UTF-16 transcoder. Takes one UTF-8 byte per beat on the byte
// channel and delivers UTF-16 code units on the unit channel. Each byte
// gives zero, one or two units: a lead byte that opens a sequence gives
// none, an ASCII byte or a completing continuation byte gives one unit, or
// a surrogate pair (two beats, run_last low on the first) for code points
// above 0xFFFF. Continuation bytes are not checked; only their low six bits
// are used. A lead byte 80-BF or F8-FF gives unit 0 with status 1, and a
// sequence still open on the byte flagged string_end gives unit 0 with
// status 2 and clears the decoder. The byte channel takes one byte every
// cycle while the four-entry result queue has room; the unit channel
// delivers one unit every cycle while results are queued and unit_stall
// is low. Each result passes through the result queue and the output beat
// register before its first unit shows at the output.

module utf8_to_utf16_transcoder (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_valid,
    output logic                        byte_stall,
    input  wire u8to16_pkg::byte_beat_t byte_beat,
    output logic                        unit_valid,
    input  wire logic                   unit_stall,
    output u8to16_pkg::unit_beat_t      unit_beat
);

    // Decoded results travel from the front decoder to the emitter here
    logic                 push;
    u8to16_pkg::entry_t   push_entry;
    logic                 q_full;
    logic                 pop;
    u8to16_pkg::q_head_t  head;

    // Front: accept bytes, advance the sequence state, classify results
    u8to16_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_beat  (byte_beat),
        .byte_stall (byte_stall),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // Queue: decouple decode from output backpressure
    u8to16_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head)
    );

    // Back: split pairs into surrogate halves and hold each output beat
    u8to16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_beat  (unit_beat)
    );

endmodule

`default_nettype wire

// ===== rtl/u8to16_front.sv =====
`default_nettype none

`include "assert_macros.svh"

module u8to16_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_valid,
    input  wire u8to16_pkg::byte_beat_t byte_beat,
    output logic                        byte_stall,
    output logic                        push,
    output u8to16_pkg::entry_t          push_entry,
    input  wire logic                   q_full
);

    logic [20:0] gathered_reg, gathered_next;
    logic [1:0]  pending_reg, pending_next;
    logic        accept;
    logic        has_result;
    logic        seq_open;
    logic [7:0]  b;
    logic [20:0] shifted;
    logic [1:0]  pend_dec;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;
    assign b          = byte_beat.in_byte;
    assign shifted    = {gathered_reg[14:0], b[5:0]};
    assign pend_dec   = pending_reg - 2'd1;

    always_comb
    begin
        gathered_next = gathered_reg;
        pending_next  = pending_reg;
        has_result    = 1'b0;
        seq_open      = 1'b0;
        push_entry    = '{pair: 1'b0, value: '0, status: u8to16_pkg::ST_OK};

        if (pending_reg == 2'd0)
        begin
            if (b[7] == 1'b0)
            begin
                gathered_next    = '0;
                has_result       = 1'b1;
                push_entry.value = {13'd0, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                gathered_next = {16'd0, b[4:0]};
                pending_next  = 2'd1;
                seq_open      = 1'b1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                gathered_next = {17'd0, b[3:0]};
                pending_next  = 2'd2;
                seq_open      = 1'b1;
            end
            else if (b[7:3] == 5'b11110)
            begin
                gathered_next = {18'd0, b[2:0]};
                pending_next  = 2'd3;
                seq_open      = 1'b1;
            end
            else
            begin
                gathered_next     = '0;
                has_result        = 1'b1;
                push_entry.status = u8to16_pkg::ST_BAD_LEAD;
            end
        end
        else
        begin
            pending_next = pend_dec;
            if (pend_dec == 2'd0)
            begin
                gathered_next    = '0;
                has_result       = 1'b1;
                push_entry.pair  = (shifted[20:16] != 5'd0);
                push_entry.value = shifted;
            end
            else
            begin
                gathered_next = shifted;
                seq_open      = 1'b1;
            end
        end

        // Drop a sequence left open at string end
        if (seq_open && byte_beat.string_end)
        begin
            gathered_next     = '0;
            pending_next      = 2'd0;
            has_result        = 1'b1;
            push_entry.value  = '0;
            push_entry.status = u8to16_pkg::ST_TRUNC;
        end
    end

    assign push = accept && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gathered_reg <= '0;
            pending_reg  <= '0;
        end
        else if (accept)
        begin
            gathered_reg <= gathered_next;
            pending_reg  <= pending_next;
        end
    end

    `ASSERT_IMPL(a_idle_clear, pending_reg == 2'd0, gathered_reg == 21'd0, "stale code point bits")

endmodule

`default_nettype wire

// ===== rtl/u8to16_fifo.sv =====
`default_nettype none

`include "assert_macros.svh"

module u8to16_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire u8to16_pkg::entry_t  push_entry,
    output logic                     full,
    input  wire logic                pop,
    output u8to16_pkg::q_head_t      head
);

    u8to16_pkg::entry_t mem [u8to16_pkg::QDepth];

    logic [u8to16_pkg::QAw-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [u8to16_pkg::QAw:0]   count_reg, count_next;

    assign full        = (count_reg == (u8to16_pkg::QAw+1)'(u8to16_pkg::QDepth));
    assign head.valid  = (count_reg != '0);
    assign head.entry  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_IMPL(a_no_overflow, push, !full, "push into full queue")
    `ASSERT_IMPL(a_no_underflow, pop, count_reg != '0, "pop from empty queue")

endmodule

`default_nettype wire

// ===== rtl/u8to16_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module u8to16_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire u8to16_pkg::q_head_t  head,
    output logic                      pop,
    output logic                      unit_valid,
    input  wire logic                 unit_stall,
    output u8to16_pkg::unit_beat_t    unit_beat
);

    logic                   out_valid_reg, out_valid_next;
    u8to16_pkg::unit_beat_t beat_reg, beat_next;
    logic                   half_reg, half_next;
    logic                   load;
    logic [20:0]            u;
    logic [15:0]            hi_unit, lo_unit;

    assign u       = head.entry.value - u8to16_pkg::SuppBase;
    assign hi_unit = u8to16_pkg::HiSurr + {5'd0, u[20:10]};
    assign lo_unit = u8to16_pkg::LoSurr + {6'd0, u[9:0]};
    assign load    = !out_valid_reg || !unit_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        beat_next      = beat_reg;
        half_next      = half_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                beat_next.status = head.entry.status;
                if (head.entry.pair && !half_reg)
                begin
                    beat_next.unit     = hi_unit;
                    beat_next.run_last = 1'b0;
                    half_next          = 1'b1;
                end
                else if (head.entry.pair)
                begin
                    beat_next.unit     = lo_unit;
                    beat_next.run_last = 1'b1;
                    half_next          = 1'b0;
                    pop                = 1'b1;
                end
                else
                begin
                    beat_next.unit     = head.entry.value[15:0];
                    beat_next.run_last = 1'b1;
                    pop                = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    assign unit_valid = out_valid_reg;
    assign unit_beat  = beat_reg;

    `ASSERT_IMPL(a_half_head, half_reg, head.valid && head.entry.pair, "low half lost its entry")
    `ASSERT_IMPL(a_mid_pair, out_valid_reg && !beat_reg.run_last, half_reg, "non-final beat w/o pair")

endmodule

`default_nettype wire
